[hdl/ulbf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Leaf block framer package
// Shared constants, opcode type, result flags and width helpers for the
// protobuf leaf block framer.
// ----------------------------------------------------------------------------
package ulbf_pkg;

  localparam int unsigned LENGTH_BITS_DEF = 32;
  localparam int unsigned PAYLOAD_W       = 32;
  localparam int unsigned RUN_DEPTH_DEF   = 4;

  typedef enum logic {
    OP_START = 1'b0,
    OP_DATA  = 1'b1
  } ulbf_op_e;

  localparam logic [7:0] TAG_NODE_DATA = 8'h0A;
  localparam logic [7:0] TAG_TYPE      = 8'h08;
  localparam logic [7:0] TYPE_FILE     = 8'h02;
  localparam logic [7:0] TAG_DATA      = 8'h12;
  localparam logic [7:0] TAG_FILESIZE  = 8'h18;
  localparam logic [7:0] CONT_BIT      = 8'h80;

  typedef struct packed {
    logic eom;
    logic err;
  } ulbf_flags_t;

  // Width of a stored (saturated) payload length.
  function automatic int unsigned ulbf_nw(input int unsigned lb);
    return (lb < PAYLOAD_W) ? lb : PAYLOAD_W;
  endfunction

  // Width of the inner message length; it may exceed a 32-bit payload length.
  function automatic int unsigned ulbf_iw(input int unsigned lb);
    return (lb > PAYLOAD_W) ? PAYLOAD_W + 1 : lb;
  endfunction

  // Longest run of bytes caused by one word: a full header.
  function automatic int unsigned ulbf_maxb(input int unsigned lb);
    return 4 + (ulbf_iw(lb) + 6) / 7 + (ulbf_nw(lb) + 6) / 7;
  endfunction

endpackage

[hdl/unixfs_leaf_block_framer_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Leaf block framer
// Wraps a file payload in a protobuf node with a file-type data message,
// emitting the encoded stream one byte per word.
// ----------------------------------------------------------------------------
// Input channel: a start word carries the payload length n and produces the
// node header (and, for n zero, the trailer too); each data word carries one
// payload byte, passed through, with the file-size trailer after the n-th.
// A word out of sequence produces a single byte with error set.
// Output channel: one encoded byte per word; last_of_run_o marks the final
// byte caused by an input word, end_of_message_o the final byte of a node.
// A run enters the run queue when its input word is accepted and is offered
// from the head; its bytes leave one per word, so data words stream at one
// per cycle while the output is not stalled; header and trailer runs of up
// to 14 bytes (at 32-bit lengths) are absorbed by a queue of RUN_DEPTH runs.
// in_stall_o rises only when that run queue is full, e.g. while the output
// is stalled; a stalled output holds its byte and flags.
// Reset empties the run queue and closes any open message.
// ----------------------------------------------------------------------------
module unixfs_leaf_block_framer_top #(
  parameter int unsigned LENGTH_BITS = ulbf_pkg::LENGTH_BITS_DEF,
  parameter int unsigned RUN_DEPTH   = ulbf_pkg::RUN_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           opcode_i,
  input  logic [ulbf_pkg::PAYLOAD_W-1:0] payload_length_i,
  input  logic [7:0]                     data_byte_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [7:0]                     out_byte_o,
  output logic                           last_of_run_o,
  output logic                           end_of_message_o,
  output logic                           error_o
);
  import ulbf_pkg::*;

  localparam int unsigned MAXB = ulbf_maxb(LENGTH_BITS);
  localparam int unsigned CW   = $clog2(MAXB + 1);

  logic              accept;
  logic              full;
  logic [MAXB*8-1:0] run_bytes;
  logic [CW-1:0]     run_count;
  ulbf_flags_t       run_flags;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  ulbf_encoder #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_encoder (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (accept),
    .opcode_i         (opcode_i),
    .payload_length_i (payload_length_i),
    .data_byte_i      (data_byte_i),
    .run_bytes_o      (run_bytes),
    .run_count_o      (run_count),
    .run_flags_o      (run_flags)
  );

  ulbf_out_buffer #(
    .MAXB  (MAXB),
    .CW    (CW),
    .DEPTH (RUN_DEPTH)
  ) u_out_buffer (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push_i           (accept),
    .run_bytes_i      (run_bytes),
    .run_count_i      (run_count),
    .run_flags_i      (run_flags),
    .full_o           (full),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_byte_o       (out_byte_o),
    .last_of_run_o    (last_of_run_o),
    .end_of_message_o (end_of_message_o),
    .error_o          (error_o)
  );

endmodule

[hdl/ulbf_encoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Leaf block framer encoder
// Holds the message state and turns one accepted word into a run of encoded
// bytes with its length and flags.
// ----------------------------------------------------------------------------
module ulbf_encoder #(
  parameter int unsigned  LENGTH_BITS = ulbf_pkg::LENGTH_BITS_DEF,
  localparam int unsigned MAXB        = ulbf_pkg::ulbf_maxb(LENGTH_BITS),
  localparam int unsigned CW          = $clog2(MAXB + 1)
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             accept_i,
  input  logic                             opcode_i,
  input  logic [ulbf_pkg::PAYLOAD_W-1:0]   payload_length_i,
  input  logic [7:0]                       data_byte_i,
  output logic [MAXB*8-1:0]                run_bytes_o,
  output logic [CW-1:0]                    run_count_o,
  output ulbf_pkg::ulbf_flags_t            run_flags_o
);
  import ulbf_pkg::*;

  localparam int unsigned NW = ulbf_nw(LENGTH_BITS);
  localparam int unsigned IW = ulbf_iw(LENGTH_BITS);
  localparam int unsigned AW = NW + 1;
  localparam int unsigned VI = (IW + 6) / 7;
  localparam int unsigned GW = $clog2(VI);
  localparam int unsigned SW = $clog2(VI + 1);
  localparam logic [PAYLOAD_W-1:0] NCAP =
    PAYLOAD_W'((64'd1 << NW) - 64'd1);

  logic [NW-1:0] rem_q, rem_d;
  logic [NW-1:0] len_q, len_d;
  logic          open_q, open_d;

  logic [PAYLOAD_W-1:0] n_sat;
  logic [NW-1:0]        n;
  logic [AW-1:0]        inner_full;
  logic [IW-1:0]        inner;
  logic [SW-1:0]        si, sn, sm;
  logic [7:0]           gi [VI];
  logic [7:0]           gn [VI];
  logic [7:0]           gm [VI];
  logic                 is_start;
  logic                 seq_err;
  logic                 data_last;

  function automatic logic [SW-1:0] vsize(input logic [IW-1:0] v);
    logic [SW-1:0] s;
    s = SW'(1);
    for (int g = 1; g < VI; g++) begin
      if ((v >> (7 * g)) != '0) s = s + SW'(1);
    end
    return s;
  endfunction

  function automatic logic [7:0] vbyte(input logic [IW-1:0] v, input logic [SW-1:0] s,
                                       input int unsigned g);
    logic [IW-1:0] sh;
    sh = v >> (7 * g);
    return ((SW'(g + 1) < s) ? CONT_BIT : 8'h00) | {1'b0, sh[6:0]};
  endfunction

  always_comb begin
    n_sat      = (payload_length_i > NCAP) ? NCAP : payload_length_i;
    n          = n_sat[NW-1:0];
    sn         = vsize(IW'(n));
    inner_full = AW'(n) + AW'(4) + AW'({sn, 1'b0});
    // The inner length saturates when it exceeds the length range and has no wider field.
    inner      = (IW == NW && inner_full[NW]) ? {IW{1'b1}} : inner_full[IW-1:0];
    si         = vsize(inner);
    sm         = vsize(IW'(len_q));
    for (int g = 0; g < VI; g++) begin
      gi[g] = vbyte(inner, si, g);
      gn[g] = vbyte(IW'(n), sn, g);
      gm[g] = vbyte(IW'(len_q), sm, g);
    end
  end

  assign is_start  = (opcode_i == OP_START);
  assign seq_err   = (is_start == open_q);
  assign data_last = (rem_q == NW'(1));

  always_comb begin
    run_bytes_o = '0;
    run_count_o = CW'(1);
    run_flags_o = '0;
    if (seq_err) begin
      run_flags_o.err = 1'b1;
    end else if (is_start) begin
      for (int i = 0; i < MAXB; i++) begin
        if (i == 0) begin
          run_bytes_o[i*8 +: 8] = TAG_NODE_DATA;
        end else if (i <= si) begin
          run_bytes_o[i*8 +: 8] = gi[GW'(i - 1)];
        end else if (i == si + 1) begin
          run_bytes_o[i*8 +: 8] = TAG_TYPE;
        end else if (i == si + 2) begin
          run_bytes_o[i*8 +: 8] = TYPE_FILE;
        end else if (i == si + 3) begin
          run_bytes_o[i*8 +: 8] = TAG_DATA;
        end else if (i < si + 4 + sn) begin
          run_bytes_o[i*8 +: 8] = gn[GW'(i - 4 - si)];
        end else if (i == si + 4 + sn) begin
          run_bytes_o[i*8 +: 8] = TAG_FILESIZE;
        end else begin
          run_bytes_o[i*8 +: 8] = 8'h00;
        end
      end
      // An empty payload closes the message with a trailer of length zero.
      run_count_o     = CW'(si) + CW'(sn) + CW'(4) + ((n == '0) ? CW'(2) : CW'(0));
      run_flags_o.eom = (n == '0);
    end else begin
      for (int i = 0; i < MAXB; i++) begin
        if (i == 0) begin
          run_bytes_o[i*8 +: 8] = data_byte_i;
        end else if (i == 1) begin
          run_bytes_o[i*8 +: 8] = TAG_FILESIZE;
        end else begin
          run_bytes_o[i*8 +: 8] = gm[GW'(i - 2)];
        end
      end
      run_count_o     = data_last ? (CW'(2) + CW'(sm)) : CW'(1);
      run_flags_o.eom = data_last;
    end
  end

  always_comb begin
    rem_d  = rem_q;
    len_d  = len_q;
    open_d = open_q;
    if (accept_i && !seq_err) begin
      if (is_start) begin
        rem_d  = n;
        len_d  = n;
        open_d = (n != '0);
      end else begin
        rem_d  = rem_q - NW'(1);
        open_d = !data_last;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      len_q  <= '0;
      open_q <= 1'b0;
    end else begin
      rem_q  <= rem_d;
      len_q  <= len_d;
      open_q <= open_d;
    end
  end

endmodule

[hdl/ulbf_out_buffer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Leaf block framer output buffer
// Queues encoded runs and hands them out one byte per word on the output
// channel.
// ----------------------------------------------------------------------------
module ulbf_out_buffer #(
  parameter int unsigned MAXB  = ulbf_pkg::ulbf_maxb(ulbf_pkg::LENGTH_BITS_DEF),
  parameter int unsigned CW    = $clog2(MAXB + 1),
  parameter int unsigned DEPTH = ulbf_pkg::RUN_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  logic [MAXB*8-1:0]     run_bytes_i,
  input  logic [CW-1:0]         run_count_i,
  input  ulbf_pkg::ulbf_flags_t run_flags_i,
  output logic                  full_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [7:0]            out_byte_o,
  output logic                  last_of_run_o,
  output logic                  end_of_message_o,
  output logic                  error_o
);
  import ulbf_pkg::*;

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned FW = $clog2(DEPTH + 1);
  localparam int unsigned BW = $clog2(MAXB);

  logic [MAXB*8-1:0] bytes_q [DEPTH];
  logic [CW-1:0]     count_q [DEPTH];
  ulbf_flags_t       flags_q [DEPTH];

  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [FW-1:0] fill_q, fill_d;
  logic [BW-1:0] idx_q, idx_d;

  logic [MAXB*8-1:0] head_bytes;
  logic [CW-1:0]     head_count;
  ulbf_flags_t       head_flags;
  logic              take;
  logic              pop;

  assign head_bytes = bytes_q[rd_ptr_q];
  assign head_count = count_q[rd_ptr_q];
  assign head_flags = flags_q[rd_ptr_q];

  assign full_o           = (fill_q == FW'(DEPTH));
  assign out_valid_o      = (fill_q != '0);
  assign out_byte_o       = head_bytes[idx_q*8 +: 8];
  assign last_of_run_o    = (CW'(idx_q) == head_count - CW'(1));
  assign end_of_message_o = last_of_run_o && head_flags.eom;
  assign error_o          = head_flags.err;

  assign take = out_valid_o && !out_stall_i;
  assign pop  = take && last_of_run_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    idx_d    = idx_q;
    fill_d   = fill_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (take) begin
      idx_d = last_of_run_o ? '0 : idx_q + BW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (push_i && !pop) begin
      fill_d = fill_q + FW'(1);
    end else if (pop && !push_i) begin
      fill_d = fill_q - FW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
      idx_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
      idx_q    <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      bytes_q[wr_ptr_q] <= run_bytes_i;
      count_q[wr_ptr_q] <= run_count_i;
      flags_q[wr_ptr_q] <= run_flags_i;
    end
  end

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Leaf block framer testbench
// Drives start and data words into the framer and predicts the encoded node
// bytes: the header, the passed-through payload, the file-size trailer and
// the single error byte for words out of sequence. A checker compares every
// accepted output byte and its flags with the oldest prediction. The sender
// and the receiver idle at random, and one long output hold fills the block.
// ----------------------------------------------------------------------------
module testbench;
  import ulbf_pkg::*;

  localparam int unsigned QUIET_LIMIT = 5000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam logic [63:0] LEN_CAP = (64'd1 << LENGTH_BITS_DEF) - 64'd1;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
    logic       eom;
    logic       err;
  } enc_byte_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic                 opcode_i;
  logic [PAYLOAD_W-1:0] payload_length_i;
  logic [7:0]           data_byte_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [7:0]           out_byte_o;
  logic                 last_of_run_o;
  logic                 end_of_message_o;
  logic                 error_o;

  enc_byte_t   expected_bytes[$];
  logic        frame_open;
  logic [31:0] payload_left;
  logic [31:0] frame_len;

  int unsigned mismatches = 0;
  int unsigned words_sent = 0;
  int unsigned quiet_cycles = 0;
  int unsigned send_gap_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_req = 0;
  int unsigned hold_ack = 0;
  int unsigned hold_left = 0;

  unixfs_leaf_block_framer_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .opcode_i        (opcode_i),
    .payload_length_i(payload_length_i),
    .data_byte_i     (data_byte_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_byte_o      (out_byte_o),
    .last_of_run_o   (last_of_run_o),
    .end_of_message_o(end_of_message_o),
    .error_o         (error_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void push_byte(input logic [7:0] value, input logic err);
    enc_byte_t e;
    e.value = value;
    e.last  = 1'b0;
    e.eom   = 1'b0;
    e.err   = err;
    expected_bytes = {expected_bytes, e};
  endfunction

  function automatic void push_varint(input logic [63:0] v);
    while (v >= 64'(CONT_BIT)) begin
      push_byte(v[7:0] | CONT_BIT, 1'b0);
      v = v >> 7;
    end
    push_byte(v[7:0], 1'b0);
  endfunction

  function automatic void push_trailer();
    push_byte(TAG_FILESIZE, 1'b0);
    push_varint(64'(frame_len));
    expected_bytes[expected_bytes.size() - 1].eom = 1'b1;
    frame_open   = 1'b0;
    payload_left = '0;
  endfunction

  function automatic void predict_word(input ulbf_op_e op, input logic [31:0] len,
                                       input logic [7:0] b);
    logic [63:0] n;
    logic [63:0] inner;
    logic [63:0] v;
    int unsigned nsize;
    if ((op == OP_START) == frame_open) begin
      // A start inside an open message or a data word with none open.
      push_byte(8'h00, 1'b1);
    end else if (op == OP_START) begin
      n = (64'(len) > LEN_CAP) ? LEN_CAP : 64'(len);
      nsize = 1;
      v = n;
      while (v >= 64'(CONT_BIT)) begin
        v = v >> 7;
        nsize++;
      end
      inner = 64'd4 + n + 64'(2 * nsize);
      if (inner > LEN_CAP) inner = LEN_CAP;
      frame_len    = n[31:0];
      payload_left = n[31:0];
      frame_open   = 1'b1;
      push_byte(TAG_NODE_DATA, 1'b0);
      push_varint(inner);
      push_byte(TAG_TYPE, 1'b0);
      push_byte(TYPE_FILE, 1'b0);
      push_byte(TAG_DATA, 1'b0);
      push_varint(n);
      if (payload_left == 0) push_trailer();
    end else begin
      push_byte(b, 1'b0);
      if (payload_left != 0) payload_left--;
      if (payload_left == 0) push_trailer();
    end
    expected_bytes[expected_bytes.size() - 1].last = 1'b1;
  endfunction

  // ------------------------------------------------------------------ checker

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    enc_byte_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch("byte with none expected", 32'(out_byte_o), 32'h0);
      end else begin
        want = expected_bytes.pop_front();
        if (out_byte_o !== want.value)
          report_mismatch("out_byte", 32'(out_byte_o), 32'(want.value));
        if (last_of_run_o !== want.last)
          report_mismatch("last_of_run", 32'(last_of_run_o), 32'(want.last));
        if (end_of_message_o !== want.eom)
          report_mismatch("end_of_message", 32'(end_of_message_o), 32'(want.eom));
        if (error_o !== want.err)
          report_mismatch("error", 32'(error_o), 32'(want.err));
      end
    end
  end

  // A hold request loads a long stall that the receiver counts down itself.
  always @(posedge clk_i) begin
    if (hold_ack != hold_req) begin
      hold_ack  = hold_req;
      hold_left = HOLD_CYCLES;
    end else if (hold_left > 0) begin
      hold_left--;
    end
    out_stall_i <= (hold_left > 0) || ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("unixfs_leaf_block_framer_top: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ------------------------------------------------------------------- driver

  // Called at a rising edge; returns at the edge where the word was taken.
  task automatic send_word(input ulbf_op_e op, input logic [31:0] len,
                           input logic [7:0] b);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    opcode_i         <= op;
    payload_length_i <= len;
    data_byte_i      <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_word(op, len, b);
    words_sent++;
  endtask

  // One message of n payload bytes, with the odd stray word mixed in.
  task automatic send_message(input int unsigned n);
    if ($urandom_range(99) < 10) send_word(OP_DATA, $urandom, 8'($urandom_range(255)));
    send_word(OP_START, n, 8'($urandom_range(255)));
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(99) < 6) send_word(OP_START, $urandom, 8'($urandom_range(255)));
      send_word(OP_DATA, $urandom, 8'($urandom_range(255)));
    end
  endtask

  // -------------------------------------------------------------------- tests

  task automatic test_data_without_message();
    send_word(OP_DATA, 32'h0000_0000, 8'h00);
    send_word(OP_DATA, 32'hFFFF_FFFF, 8'hFF);
  endtask

  task automatic test_empty_payload();
    send_word(OP_START, 32'h0, 8'hFF);
    send_word(OP_START, 32'h0, 8'h00);
  endtask

  task automatic test_start_while_open();
    send_word(OP_START, 32'd3, 8'h00);
    send_word(OP_START, 32'hFFFF_FFFF, 8'hFF);
    send_word(OP_DATA, 32'h0, 8'h00);
    send_word(OP_DATA, 32'h0, 8'hFF);
    send_word(OP_START, 32'h0, 8'h00);
    send_word(OP_DATA, 32'hFFFF_FFFF, 8'hA5);
  endtask

  task automatic test_random_framing(input int unsigned budget);
    int unsigned stop_at;
    stop_at = words_sent + budget;
    while (words_sent < stop_at)
      send_message(($urandom_range(99) < 15) ? 0 : $urandom_range(1, 12));
  endtask

  // 128 bytes make both the inner length and n two-byte varints.
  task automatic test_two_byte_varints();
    send_message(128);
  endtask

  task automatic test_output_hold();
    hold_req++;
    repeat (8) send_message($urandom_range(0, 3));
  endtask

  // The largest length gives the longest header and a clamped inner length.
  // That message never closes, so this runs last.
  task automatic test_saturated_length();
    send_word(OP_START, 32'hFFFF_FFFF, 8'h00);
    send_word(OP_DATA, 32'h0, 8'h00);
    send_word(OP_DATA, 32'hFFFF_FFFF, 8'hFF);
    send_word(OP_START, 32'h8000_0000, 8'h5A);
    send_word(OP_DATA, 32'h0, 8'h5A);
  endtask

  initial begin
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    opcode_i         = OP_START;
    payload_length_i = '0;
    data_byte_i      = '0;
    out_stall_i      = 1'b0;
    frame_open       = 1'b0;
    payload_left     = '0;
    frame_len        = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_gap_pct   = 38;
    recv_stall_pct = 77;
    test_data_without_message();
    test_empty_payload();
    test_start_while_open();
    test_random_framing(75);

    send_gap_pct   = 77;
    recv_stall_pct = 38;
    test_random_framing(75);

    send_gap_pct   = 0;
    recv_stall_pct = 0;
    test_random_framing(75);
    test_two_byte_varints();
    test_output_hold();
    test_saturated_length();

    in_valid_i <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("unixfs_leaf_block_framer_top: match");
    end else begin
      $display("unixfs_leaf_block_framer_top: mismatch");
    end
    $finish;
  end

endmodule
